// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// consequence must hold in the same cycle as the trigger
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// consequence must hold in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== sv/deq_pkg.sv =====
// shared types and constants of the deque with id search
package deq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        key;
    logic [63:0]        value;
    logic [63:0]        tstamp;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_SHIFT_R = 2'd2,
    CELL_SHIFT_L = 2'd3
  } cell_cmd_t;

endpackage

// ===== sv/deque_with_id_search_top.sv =====
// top level of the deque with id search: control, cell ring and result register
`include "assert_macros.svh"

// Bounded double-ended queue of DEPTH records (id, key, value, timestamp) held in a
// ring of DEPTH cells; outside a search cell 0 holds the front record and the live
// records occupy cells 0 to entry_count-1. Every request gives exactly one response with a
// status and the entry count after the operation. Push front shifts the whole row
// one cell toward the back and loads cell 0; push back loads the first free cell;
// pop front shifts the row one cell toward the front; pop back only drops the
// count. These are answered at once: the response is registered at the edge that
// accepts the request. A search rotates the ring one cell per cycle, DEPTH cells
// in all, comparing cell 0 against the sought id while the rotation is within the
// live records, so the ring is back in order when it ends; its response is
// registered in the finish state after the rotation, once the response register
// is free. The rotation length of the cell ring sets the search time. A new
// request is taken only when the block is idle and the response register is
// empty or being drained in the same cycle. No clearing pass runs after reset;
// empty cells are never read.
module deque_with_id_search_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] rec_id,
  input  logic [63:0]        rec_key,
  input  logic [63:0]        rec_value,
  input  logic [63:0]        rec_time,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic signed [31:0] found_id,
  output logic [63:0]        found_key,
  output logic [63:0]        found_value,
  output logic [63:0]        found_time,
  output logic [CNT_W-1:0]   entry_count
);

  // controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [STEP_W-1:0]  step;
  logic signed [31:0] want;
  logic               hit;
  rec_t               hit_rec;

  rec_t               in_rec;
  rec_t               cells [DEPTH];
  cell_cmd_t          cmd [DEPTH];

  logic req_fire;
  logic full;
  logic empty;
  logic rsp_free;
  logic probe_hit;
  logic push_op;

  // outcome of a request that is answered at once
  logic [1:0]       quick_status;
  logic [CNT_W-1:0] count_next;
  logic             start_search;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign req_fire  = req_valid && req_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign push_op   = (opcode == OP_PUSH_FRONT) || (opcode == OP_PUSH_BACK);

  assign in_rec.id     = rec_id;
  assign in_rec.key    = rec_key;
  assign in_rec.value  = rec_value;
  assign in_rec.tstamp = rec_time;

  // cell 0 holds the record at offset step of the rotation
  assign probe_hit = (state == S_SEARCH) && !hit && (CNT_W'(step) < count) &&
                     (cells[0].id == want);

  // status and count for the incoming request, or a search to start
  always_comb begin
    quick_status = ST_OK;
    count_next   = count;
    start_search = 1'b0;
    case (opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) quick_status = ST_FULL;
        else count_next = count + 1'b1;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) quick_status = ST_EMPTY;
        else count_next = count - 1'b1;
      end
      OP_SEARCH: begin
        if (empty) quick_status = ST_EMPTY;
        else start_search = 1'b1;
      end
      default: quick_status = ST_OK;
    endcase
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i] = CELL_HOLD;
      if (req_fire) begin
        case (opcode)
          OP_PUSH_FRONT: begin
            if (!full) cmd[i] = (i == 0) ? CELL_LOAD : CELL_SHIFT_R;
          end
          OP_PUSH_BACK: begin
            if (!full && (CNT_W'(i) == count)) cmd[i] = CELL_LOAD;
          end
          OP_POP_FRONT: begin
            if (!empty) cmd[i] = CELL_SHIFT_L;
          end
          default: cmd[i] = CELL_HOLD;
        endcase
      end else if (state == S_SEARCH) begin
        cmd[i] = CELL_SHIFT_L;
      end
    end
  end

  // ring of cells, each tied to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    deq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd[g]),
      .load_rec  (in_rec),
      .left_rec  (cells[(g + DEPTH - 1) % DEPTH]),
      .right_rec (cells[(g + 1) % DEPTH]),
      .rec       (cells[g])
    );
  end

  // control, count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            found_id    <= '0;
            found_key   <= '0;
            found_value <= '0;
            found_time  <= '0;
            status      <= quick_status;
            count       <= count_next;
            entry_count <= count_next;
            // a search answers after the rotation
            rsp_valid   <= !start_search;
            if (start_search) begin
              state <= S_SEARCH;
              step  <= '0;
              want  <= rec_id;
              hit   <= 1'b0;
            end
          end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_SEARCH: begin
          step <= step + 1'b1;
          if (probe_hit) begin
            hit     <= 1'b1;
            hit_rec <= cells[0];
          end
          if (step == STEP_W'(DEPTH - 1)) state <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp_valid   <= 1'b1;
            entry_count <= count;
            status      <= hit ? ST_OK : ST_MISSING;
            found_id    <= hit ? hit_rec.id : '0;
            found_key   <= hit ? hit_rec.key : '0;
            found_value <= hit ? hit_rec.value : '0;
            found_time  <= hit ? hit_rec.tstamp : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_search_nonempty, state != S_IDLE, count != '0)
  `ASSERT_NEXT(a_count_frozen, state != S_IDLE, $stable(count))
  `ASSERT_NEXT(a_full_push, req_fire && full && push_op, rsp_valid && status == ST_FULL)

endmodule

// ===== sv/deq_cell.sv =====
// one record cell of the deque ring
module deq_cell
  import deq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  rec_t      load_rec,
  input  rec_t      left_rec,
  input  rec_t      right_rec,
  output rec_t      rec
);

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_LOAD:    rec <= load_rec;
      CELL_SHIFT_R: rec <= left_rec;
      CELL_SHIFT_L: rec <= right_rec;
      CELL_HOLD:    rec <= rec;
      default:      rec <= rec;
    endcase
  end

endmodule
